// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define GLMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glmt: same-cycle check failed");

// next-cycle implication, checked out of reset
`define GLMT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glmt: next-cycle check failed");

`endif

// ----- hw/rtl/glmt_pkg.sv -----
`default_nettype none

package glmt_pkg;

    localparam int VOCAB_ENTRIES = 4096;
    localparam int MAX_PIECE_LEN = 16;
    localparam int WIN_SIZE      = 16;

    localparam int ADDR_W    = $clog2(VOCAB_ENTRIES);
    localparam int CNT_W     = $clog2(VOCAB_ENTRIES + 1);
    localparam int LEN_W     = $clog2(MAX_PIECE_LEN + 1);
    localparam int POS_W     = (MAX_PIECE_LEN > 1) ? $clog2(MAX_PIECE_LEN) : 1;
    localparam int FILL_W    = $clog2(WIN_SIZE + 1);
    localparam int WIN_IDX_W = $clog2(WIN_SIZE);
    localparam int CMP_LEN   = (MAX_PIECE_LEN < WIN_SIZE) ? MAX_PIECE_LEN : WIN_SIZE;

    // fixed field widths
    localparam int CMD_W   = 3;
    localparam int ID_W    = 12;
    localparam int BYTE_W  = 8;
    localparam int PLEN_W  = 5;
    localparam int VCNT_W  = 13;
    localparam int CIDX_W  = 2;

    localparam int BYTE_TOKEN_OFFSET = 3;

    localparam logic [CIDX_W-1:0] CFG_VOCAB_COUNT = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_BOS_TOKEN   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_EOS_TOKEN   = 2'd2;

    localparam logic [ID_W-1:0] BOS_RESET = 12'd2;
    localparam logic [ID_W-1:0] EOS_RESET = 12'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_WBYTE  = 3'd0,
        CMD_WLEN   = 3'd1,
        CMD_START  = 3'd2,
        CMD_TEXT   = 3'd3,
        CMD_DECODE = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        OP_WBYTE,
        OP_WLEN,
        OP_START,
        OP_TEXT,
        OP_DECODE
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              wr_ok;
        logic [ID_W-1:0]   entry;
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] pbyte;
        logic [LEN_W-1:0]  plen;
        logic [BYTE_W-1:0] tbyte;
        logic              last;
        logic [ID_W-1:0]   tid;
    } t_item;

    typedef struct packed {
        logic              we;
        logic [CIDX_W-1:0] idx;
        logic [VCNT_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic              clearing;
        logic [FILL_W-1:0] fill;
    } t_stat;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MATCH,
        S_DCHECK,
        S_DEMIT
    } t_state;

endpackage

`default_nettype wire

// ----- hw/rtl/glmt_if.sv -----
`default_nettype none

interface glmt_in_if import glmt_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ID_W-1:0]   entry_index;
    logic [3:0]        byte_position;
    logic [BYTE_W-1:0] piece_byte;
    logic [PLEN_W-1:0] piece_len;
    logic [BYTE_W-1:0] text_byte;
    logic              seq_last;
    logic [ID_W-1:0]   token_id;

    modport source (output valid, command, entry_index, byte_position, piece_byte,
                    piece_len, text_byte, seq_last, token_id, input ready);
    modport sink   (input valid, command, entry_index, byte_position, piece_byte,
                    piece_len, text_byte, seq_last, token_id, output ready);
endinterface

interface glmt_out_if import glmt_pkg::*;;
    logic              valid;
    logic              ready;
    logic              result_kind;
    logic [ID_W-1:0]   token_out;
    logic [BYTE_W-1:0] byte_out;
    logic              run_last;

    modport source (output valid, result_kind, token_out, byte_out, run_last, input ready);
    modport sink   (input valid, result_kind, token_out, byte_out, run_last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/glmt_ram.sv -----
`default_nettype none

module glmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/glmt_front.sv -----
`default_nettype none

module glmt_front import glmt_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    glmt_in_if.sink    i_txt,
    input  wire logic  i_hold,
    output      logic  o_q_valid,
    output      t_item o_q_item,
    input  wire logic  i_q_pop
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic       w_keep;
    logic       w_push;

    assign i_txt.ready = !i_hold && (r_cnt != 2'd2);

    always_comb begin
        w_item.op    = OP_WBYTE;
        w_item.entry = i_txt.entry_index;
        w_item.pos   = i_txt.byte_position[POS_W-1:0];
        w_item.pbyte = i_txt.piece_byte;
        w_item.plen  = (32'(i_txt.piece_len) > MAX_PIECE_LEN) ?
                       LEN_W'(MAX_PIECE_LEN) : LEN_W'(i_txt.piece_len);
        w_item.tbyte = i_txt.text_byte;
        w_item.last  = i_txt.seq_last;
        w_item.tid   = i_txt.token_id;
        w_item.wr_ok = (32'(i_txt.entry_index) < VOCAB_ENTRIES);
        w_keep       = 1'b1;
        unique case (i_txt.command)
            CMD_WBYTE: begin
                w_item.op    = OP_WBYTE;
                w_item.wr_ok = (32'(i_txt.entry_index) < VOCAB_ENTRIES) &&
                               (32'(i_txt.byte_position) < MAX_PIECE_LEN);
            end
            CMD_WLEN:   w_item.op = OP_WLEN;
            CMD_START:  w_item.op = OP_START;
            CMD_TEXT:   w_item.op = OP_TEXT;
            CMD_DECODE: w_item.op = OP_DECODE;
            // unused codes are taken and dropped
            default:    w_keep = 1'b0;
        endcase
    end

    assign w_push = i_txt.valid && i_txt.ready && w_keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
    end

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

endmodule

`default_nettype wire

// ----- hw/rtl/glmt_back.sv -----
`default_nettype none

module glmt_back import glmt_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg_wr i_cfg,
    input  wire logic    i_q_valid,
    input  wire t_item   i_q_item,
    output      logic    o_q_pop,
    glmt_out_if.source   o_res,
    output      t_stat   o_stat
);

    t_state r_state, n_state;

    logic [VCNT_W-1:0] r_vcnt;
    logic [ID_W-1:0]   r_bos;
    logic [ID_W-1:0]   r_eos;

    logic [BYTE_W-1:0] r_win [WIN_SIZE];
    logic [BYTE_W-1:0] n_win [WIN_SIZE];
    logic [FILL_W-1:0] r_fill, n_fill;

    logic [CNT_W-1:0]  r_scan, n_scan;
    logic              r_pend, n_pend;
    logic [ADDR_W-1:0] r_pend_idx, n_pend_idx;
    logic [LEN_W-1:0]  r_top_len, n_top_len;
    logic [ADDR_W-1:0] r_best_id, n_best_id;
    logic              r_lastm, n_lastm;

    logic [ID_W-1:0]   r_tid, n_tid;
    logic [BYTE_W-1:0] r_row [MAX_PIECE_LEN];
    logic [BYTE_W-1:0] n_row [MAX_PIECE_LEN];
    logic [LEN_W-1:0]  r_dlen, n_dlen;
    logic [LEN_W-1:0]  r_j, n_j;

    logic [ADDR_W-1:0] r_clr;

    logic              r_out_v, n_out_v;
    logic              r_out_kind, n_out_kind;
    logic [ID_W-1:0]   r_out_tok, n_out_tok;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_out_last, n_out_last;

    logic                     len_we;
    logic [ADDR_W-1:0]        len_waddr;
    logic [LEN_W-1:0]         len_wdata;
    logic [MAX_PIECE_LEN-1:0] byte_we;
    logic [ADDR_W-1:0]        rd_addr;
    logic [LEN_W-1:0]         rd_len;
    logic [BYTE_W-1:0]        rd_byte [MAX_PIECE_LEN];

    logic              out_free;
    logic              pop;
    logic [CNT_W-1:0]  vcnt_eff;
    logic [FILL_W-1:0] fill_add;
    logic              text_go;
    logic              scan_issue;
    logic              hit;
    logic [ID_W-1:0]   m_tok;
    logic [FILL_W-1:0] m_drop;
    logic [FILL_W-1:0] fill_after;
    logic [BYTE_W-1:0] win_sh [WIN_SIZE];
    logic              dec_ok;
    logic              dem_last;

    // storage: one byte lane per piece position plus the length table
    glmt_ram #(.WIDTH(LEN_W), .DEPTH(VOCAB_ENTRIES)) u_len (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_len)
    );

    for (genvar g = 0; g < MAX_PIECE_LEN; g++) begin : g_lane
        glmt_ram #(.WIDTH(BYTE_W), .DEPTH(VOCAB_ENTRIES)) u_lane (
            .i_clk   (i_clk),
            .i_we    (byte_we[g]),
            .i_waddr (i_q_item.entry[ADDR_W-1:0]),
            .i_wdata (i_q_item.pbyte),
            .i_raddr (rd_addr),
            .o_rdata (rd_byte[g])
        );
    end

    assign out_free = !r_out_v || o_res.ready;
    assign pop      = (r_state == S_IDLE) && i_q_valid && out_free;
    assign o_q_pop  = pop;

    assign vcnt_eff = (32'(r_vcnt) > VOCAB_ENTRIES) ? CNT_W'(VOCAB_ENTRIES) : CNT_W'(r_vcnt);

    assign fill_add = (32'(r_fill) < WIN_SIZE) ? r_fill + FILL_W'(1) : r_fill;
    assign text_go  = ((32'(fill_add) >= WIN_SIZE) && !i_q_item.last) ||
                      (i_q_item.last && (fill_add != '0));

    assign scan_issue = (r_scan < vcnt_eff);

    always_comb begin
        hit = r_pend && (rd_len > r_top_len) && (32'(rd_len) <= 32'(r_fill));
        for (int j = 0; j < CMP_LEN; j++) begin
            if ((32'(rd_len) > j) && (rd_byte[j] != r_win[j])) begin
                hit = 1'b0;
            end
        end
    end

    // no matching piece falls back to the byte token
    assign m_tok  = (r_top_len != '0) ? ID_W'(r_best_id) :
                    ID_W'(r_win[0]) + ID_W'(BYTE_TOKEN_OFFSET);
    assign m_drop = (r_top_len != '0) ? FILL_W'(r_top_len) : FILL_W'(1);
    assign fill_after = r_fill - m_drop;

    always_comb begin
        int sum;
        for (int k = 0; k < WIN_SIZE; k++) begin
            sum = k + 32'(m_drop);
            win_sh[k] = (sum < WIN_SIZE) ? r_win[sum[WIN_IDX_W-1:0]] : '0;
        end
    end

    assign dec_ok = (32'(r_tid) < 32'(vcnt_eff)) && (rd_len != '0) &&
                    (r_tid != r_bos) && (r_tid != r_eos);
    assign dem_last = (r_j == r_dlen - LEN_W'(1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == ADDR_W'(VOCAB_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (pop) begin
                    if (i_q_item.op == OP_TEXT && text_go) begin
                        n_state = S_SCAN;
                    end else if (i_q_item.op == OP_DECODE) begin
                        n_state = S_DCHECK;
                    end
                end
            end
            S_SCAN: begin
                if (!scan_issue && !r_pend) begin
                    n_state = S_MATCH;
                end
            end
            S_MATCH: begin
                if (out_free) begin
                    n_state = (r_lastm && fill_after != '0) ? S_SCAN : S_IDLE;
                end
            end
            S_DCHECK: n_state = dec_ok ? S_DEMIT : S_IDLE;
            S_DEMIT: begin
                if (out_free && dem_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_win      = r_win;
        n_fill     = r_fill;
        n_scan     = r_scan;
        n_pend     = 1'b0;
        n_pend_idx = r_pend_idx;
        n_top_len  = r_top_len;
        n_best_id  = r_best_id;
        n_lastm    = r_lastm;
        n_tid      = r_tid;
        n_row      = r_row;
        n_dlen     = r_dlen;
        n_j        = r_j;
        n_out_v    = r_out_v && !o_res.ready;
        n_out_kind = r_out_kind;
        n_out_tok  = r_out_tok;
        n_out_byte = r_out_byte;
        n_out_last = r_out_last;
        len_we     = 1'b0;
        len_waddr  = i_q_item.entry[ADDR_W-1:0];
        len_wdata  = i_q_item.plen;
        byte_we    = '0;
        rd_addr    = r_tid[ADDR_W-1:0];

        unique case (r_state)
            S_CLEAR: begin
                len_we    = 1'b1;
                len_waddr = r_clr;
                len_wdata = '0;
            end
            S_IDLE: begin
                rd_addr = i_q_item.tid[ADDR_W-1:0];
                if (pop) begin
                    unique case (i_q_item.op)
                        OP_WBYTE: byte_we[i_q_item.pos] = i_q_item.wr_ok;
                        OP_WLEN:  len_we = i_q_item.wr_ok;
                        OP_START: begin
                            for (int k = 0; k < WIN_SIZE; k++) begin
                                n_win[k] = '0;
                            end
                            n_fill     = '0;
                            n_out_v    = 1'b1;
                            n_out_kind = 1'b0;
                            n_out_tok  = r_bos;
                            n_out_byte = '0;
                            n_out_last = 1'b1;
                        end
                        OP_TEXT: begin
                            if (32'(r_fill) < WIN_SIZE) begin
                                n_win[r_fill[WIN_IDX_W-1:0]] = i_q_item.tbyte;
                            end
                            n_fill     = fill_add;
                            n_lastm    = i_q_item.last;
                            n_scan     = '0;
                            n_top_len  = '0;
                            n_best_id  = '0;
                        end
                        OP_DECODE: n_tid = i_q_item.tid;
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                rd_addr    = r_scan[ADDR_W-1:0];
                n_pend     = scan_issue;
                n_pend_idx = r_scan[ADDR_W-1:0];
                if (scan_issue) begin
                    n_scan = r_scan + CNT_W'(1);
                end
                if (hit) begin
                    n_top_len = rd_len;
                    n_best_id = r_pend_idx;
                end
            end
            S_MATCH: begin
                if (out_free) begin
                    n_out_v    = 1'b1;
                    n_out_kind = 1'b0;
                    n_out_tok  = m_tok;
                    n_out_byte = '0;
                    n_out_last = r_lastm ? (fill_after == '0) : 1'b1;
                    n_win      = win_sh;
                    n_fill     = fill_after;
                    n_scan     = '0;
                    n_top_len  = '0;
                    n_best_id  = '0;
                end
            end
            S_DCHECK: begin
                n_row  = rd_byte;
                n_dlen = rd_len;
                n_j    = '0;
            end
            S_DEMIT: begin
                if (out_free) begin
                    n_out_v    = 1'b1;
                    n_out_kind = 1'b1;
                    n_out_tok  = r_tid;
                    n_out_byte = r_row[r_j[POS_W-1:0]];
                    n_out_last = dem_last;
                    n_j        = r_j + LEN_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_vcnt  <= '0;
            r_bos   <= BOS_RESET;
            r_eos   <= EOS_RESET;
            r_fill  <= '0;
            r_pend  <= 1'b0;
            r_out_v <= 1'b0;
            for (int k = 0; k < WIN_SIZE; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            if (i_cfg.we) begin
                if (i_cfg.idx == CFG_VOCAB_COUNT) begin
                    r_vcnt <= i_cfg.data;
                end else if (i_cfg.idx == CFG_BOS_TOKEN) begin
                    r_bos <= i_cfg.data[ID_W-1:0];
                end else if (i_cfg.idx == CFG_EOS_TOKEN) begin
                    r_eos <= i_cfg.data[ID_W-1:0];
                end
            end
            r_fill  <= n_fill;
            r_win   <= n_win;
            r_pend  <= n_pend;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan     <= n_scan;
        r_pend_idx <= n_pend_idx;
        r_top_len  <= n_top_len;
        r_best_id  <= n_best_id;
        r_lastm    <= n_lastm;
        r_tid      <= n_tid;
        r_row      <= n_row;
        r_dlen     <= n_dlen;
        r_j        <= n_j;
        r_out_kind <= n_out_kind;
        r_out_tok  <= n_out_tok;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_res.valid       = r_out_v;
    assign o_res.result_kind = r_out_kind;
    assign o_res.token_out   = r_out_tok;
    assign o_res.byte_out    = r_out_byte;
    assign o_res.run_last    = r_out_last;

    assign o_stat.clearing = (r_state == S_CLEAR);
    assign o_stat.fill     = r_fill;

endmodule

`default_nettype wire

// ----- hw/rtl/greedy_longest_match_tokenizer_unit.sv -----
// channel   dir  handshake      payload
// i_txt     in   valid/ready    command, entry_index, byte_position, piece_byte,
//                               piece_len, text_byte, seq_last, token_id
// o_res     out  valid/ready    result_kind, token_out, byte_out, run_last
// i_cfg_*   in   write enable   i_cfg_idx, i_cfg_data
//
// after reset the length table is swept to zero with i_txt.ready low
// each emitted token scans the vocabulary one entry a cycle through the length and
// byte-lane read port, up to 16 scans at a last byte
// a 2-entry queue decouples intake from the scan; results sit in an output register
// and the match step holds while o_res is stalled

`default_nettype none

`include "assert_macros.svh"

module greedy_longest_match_tokenizer_unit import glmt_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CIDX_W-1:0] i_cfg_idx,
    input  wire logic [VCNT_W-1:0] i_cfg_data,
    glmt_in_if.sink                i_txt,
    glmt_out_if.source             o_res
);

    t_cfg_wr w_cfg;
    t_item   w_q_item;
    logic    w_q_valid;
    logic    w_q_pop;
    t_stat   w_stat;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = i_cfg_idx;
    assign w_cfg.data = i_cfg_data;

    glmt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_txt     (i_txt),
        .i_hold    (w_stat.clearing),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item),
        .i_q_pop   (w_q_pop)
    );

    glmt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_q_pop),
        .o_res     (o_res),
        .o_stat    (w_stat)
    );

    `GLMT_ASSERT_IMP(a_clear_blocks_in, i_clk, i_rst_n, w_stat.clearing, !i_txt.ready)
    `GLMT_ASSERT_IMP(a_clear_no_result, i_clk, i_rst_n, w_stat.clearing, !o_res.valid)
    `GLMT_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, 32'(w_stat.fill) <= WIN_SIZE)
    `GLMT_ASSERT_NXT(a_clear_once, i_clk, i_rst_n, !w_stat.clearing, !w_stat.clearing)

endmodule

`default_nettype wire
